// ===== design/mean_filter_3x3_defines.svh =====
// Assertion macros for the mean filter blocks.
// No dependencies; included by the modules that carry assertions.
`ifndef MEAN_FILTER_3X3_DEFINES_SVH
`define MEAN_FILTER_3X3_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/mf3_pkg.sv =====
// Types, constants and the divide-by-nine function of the 3x3 mean filter.
// No dependencies.
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int SUM_W      = 12;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // floor(sum / 9) for sum < 2304 as (sum * ceil(2^16 / 9)) >> 16
    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } t_tag;

    typedef struct packed {
        logic produced;
        t_tag tag;
    } t_item;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [SUM_W+12:0] prod;
        prod = sum * DIV9_RECIP;
        return prod[23:16];
    endfunction

endpackage

// ===== design/mf3_line_mem.sv =====
// Line memory holding the upper and middle rows side by side in one word.
// Synchronous read whose data is registered; no dependencies.
module mf3_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mf3_window.sv =====
// Six-pixel window of the two previous columns and the nine-pixel sum stage.
// Depends on mf3_pkg.
module mf3_window
    import mf3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s1_valid,
    input  t_item            i_s1_item,
    input  logic [PIX_W-1:0] i_pix,
    input  logic [PIX_W-1:0] i_up,
    input  logic [PIX_W-1:0] i_mid,
    output logic             o_s2_valid,
    output logic [SUM_W-1:0] o_s2_sum,
    output t_tag             o_s2_tag
);

    logic [PIX_W-1:0] r_win [6];
    logic             r_s2_valid;
    logic [SUM_W-1:0] r_s2_sum;
    t_tag             r_s2_tag;
    logic [SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = SUM_W'(i_up) + SUM_W'(i_mid) + SUM_W'(i_pix);
        for (int k = 0; k < 6; k++) begin
            n_sum = n_sum + SUM_W'(r_win[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid && i_s1_item.produced;
            if (i_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= i_up;
                r_win[4] <= i_mid;
                r_win[5] <= i_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid) begin
            r_s2_sum <= n_sum;
            r_s2_tag <= i_s1_item.tag;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2_sum   = r_s2_sum;
    assign o_s2_tag   = r_s2_tag;

endmodule

// ===== design/mf3_out_fifo.sv =====
// Divide-by-nine and four-entry output queue feeding the result channel.
// Depends on mf3_pkg.
module mf3_out_fifo
    import mf3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [SUM_W-1:0]   i_sum,
    input  t_tag               i_tag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_mean_value,
    output t_tag               o_tag,
    output logic [FIFO_CW-1:0] o_level
);

    logic [PIX_W-1:0]   r_mean [FIFO_DEPTH];
    t_tag               r_tag  [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_level;
    logic               w_pop;

    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !w_pop) begin
                r_level <= r_level + FIFO_CW'(1);
            end else if (!i_push && w_pop) begin
                r_level <= r_level - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mean[r_wr_ptr] <= div9(i_sum);
            r_tag[r_wr_ptr]  <= i_tag;
        end
    end

    assign o_valid      = (r_level != '0);
    assign o_mean_value = r_mean[r_rd_ptr];
    assign o_tag        = r_tag[r_rd_ptr];
    assign o_level      = r_level;

endmodule

// ===== design/mean_filter_3x3.sv =====
// 3x3 mean filter over 8-bit grayscale frames streamed in raster order. One pixel is
// taken per clock; the two previous rows sit in one line memory whose synchronous
// read is issued as the pixel is taken. In the next cycle the read data and the
// six-pixel window form the nine-pixel sum, and in the cycle after that the sum is
// divided by nine as it is written into a four-entry output queue. For every interior
// centre one result is presented for the pixel that completes its window; border
// pixels give none. The input stalls only when results back up, once the queue entries
// in use and the items in the two pipeline stages reach four. Writing either size
// register restarts the frame; no clearing pass follows reset.
// Depends on mf3_pkg, mf3_line_mem, mf3_window and mf3_out_fifo.
`include "mean_filter_3x3_defines.svh"

module mean_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [PIX_W-1:0]         i_pixel,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [PIX_W-1:0]         o_mean_value,
    output logic [ROW_W-1:0]         o_centre_row,
    output logic [COL_W-1:0]         o_centre_col,
    output logic                     o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic               r_s1_valid;
    t_item              r_s1_item;
    logic [CW-1:0]      r_s1_col;
    logic [PIX_W-1:0]   r_s1_pix;

    logic               w_cfg_wr;
    logic               w_accept;
    logic [CW-1:0]      w_col_last;
    logic [RW-1:0]      w_row_last;
    t_item              w_item;
    logic [2*PIX_W-1:0] w_rd_data;
    logic               w_s2_valid;
    logic [SUM_W-1:0]   w_s2_sum;
    t_tag               w_s2_tag;
    t_tag               w_out_tag;
    logic [FIFO_CW-1:0] w_level;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = {20'b0, r_frame_width};
            REG_FRAME_HEIGHT: prdata = {19'b0, r_frame_height};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_width < FW_W'(3)) begin
            w_col_last = CW'(2);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_col_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_col_last = CW'(r_frame_width - FW_W'(1));
        end
        if (r_frame_height < FH_W'(3)) begin
            w_row_last = RW'(2);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            w_row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            w_row_last = RW'(r_frame_height - FH_W'(1));
        end
    end

    assign o_ready  = (4'(w_level) + 4'(r_s1_valid) + 4'(w_s2_valid)) < 4'(FIFO_DEPTH);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_item.produced       = (r_row >= RW'(2)) && (r_col >= CW'(2));
        w_item.tag.centre_row = ROW_W'(r_row - RW'(1));
        w_item.tag.centre_col = COL_W'(r_col - CW'(1));
        w_item.tag.frame_last = (r_row == w_row_last) && (r_col == w_col_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_cfg_wr) begin
                case (t_reg_idx'(paddr[2]))
                    REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                    default:          r_frame_width  <= r_frame_width;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (w_accept) begin
                if (r_col == w_col_last) begin
                    r_col <= '0;
                    r_row <= (r_row == w_row_last) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= w_item;
            r_s1_col  <= r_col;
            r_s1_pix  <= i_pixel;
        end
    end

    mf3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PIX_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({w_rd_data[PIX_W-1:0], r_s1_pix})
    );

    mf3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1_item  (r_s1_item),
        .i_pix      (r_s1_pix),
        .i_up       (w_rd_data[2*PIX_W-1:PIX_W]),
        .i_mid      (w_rd_data[PIX_W-1:0]),
        .o_s2_valid (w_s2_valid),
        .o_s2_sum   (w_s2_sum),
        .o_s2_tag   (w_s2_tag)
    );

    mf3_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_s2_valid),
        .i_sum        (w_s2_sum),
        .i_tag        (w_s2_tag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mean_value (o_mean_value),
        .o_tag        (w_out_tag),
        .o_level      (w_level)
    );

    assign o_centre_row = w_out_tag.centre_row;
    assign o_centre_col = w_out_tag.centre_col;
    assign o_frame_last = w_out_tag.frame_last;

    `MF3_ASSERT_IMP(a_no_queue_overflow, i_clk, i_rst_n, w_s2_valid,
                    w_level < FIFO_CW'(FIFO_DEPTH), "output queue pushed while full")
    `MF3_ASSERT_IMP(a_no_addr_clash, i_clk, i_rst_n, w_accept && r_s1_valid,
                    r_col != r_s1_col, "line memory read and write hit one entry")
    `MF3_ASSERT_IMP(a_col_in_range, i_clk, i_rst_n, 1'b1,
                    r_col <= w_col_last, "column counter beyond row end")
    `MF3_ASSERT_NXT(a_cfg_restart, i_clk, i_rst_n, w_cfg_wr,
                    r_col == '0 && r_row == '0, "size write did not restart frame")

endmodule

// ===== tb/mean_filter_3x3_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 3x3 mean filter: tracks size register writes and accepted
// pixels, predicts each window mean and compares it with the result channel.
// Depends on mf3_pkg.
module mean_filter_3x3_checker
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    input  logic             i_pready,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [PIX_W-1:0] i_mean_value,
    input  logic [ROW_W-1:0] i_centre_row,
    input  logic [COL_W-1:0] i_centre_col,
    input  logic             i_frame_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] mean_value;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } t_window_mean;

    t_window_mean     means_due[$];
    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] window_px [6];
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [ROW_W-1:0] row_at;
    logic [COL_W-1:0] col_at;
    int               mismatches;

    function automatic int saturate_size(input int size, input int size_max);
        return (size < 3) ? 3 : ((size > size_max) ? size_max : size);
    endfunction

    task automatic slide_window(input logic [PIX_W-1:0] pix);
        int               w;
        int               h;
        int               row;
        int               col;
        int               sum;
        int               k;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        t_window_mean     mean_out;
        w   = saturate_size(int'(width_reg), MAX_WIDTH);
        h   = saturate_size(int'(height_reg), MAX_HEIGHT);
        row = int'(row_at);
        col = int'(col_at);
        up  = upper_line[col];
        mid = middle_line[col];
        if (row >= 2 && col >= 2) begin
            sum = int'(up) + int'(mid) + int'(pix);
            for (k = 0; k < 6; k++) sum += int'(window_px[k]);
            mean_out.mean_value = PIX_W'(sum / 9);
            mean_out.centre_row = ROW_W'(row - 1);
            mean_out.centre_col = COL_W'(col - 1);
            mean_out.frame_last = (row == h - 1 && col == w - 1);
            means_due.push_back(mean_out);
        end
        for (k = 0; k < 3; k++) window_px[k] = window_px[k + 3];
        window_px[3]     = up;
        window_px[4]     = mid;
        window_px[5]     = pix;
        upper_line[col]  = mid;
        middle_line[col] = pix;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_at = COL_W'(col);
        row_at = ROW_W'(row);
    endtask

    task automatic compare_mean();
        t_window_mean due;
        if (means_due.size() == 0) begin
            $error("unexpected result: mean_value %0d centre_row %0d centre_col %0d",
                   i_mean_value, i_centre_row, i_centre_col);
            mismatches++;
        end else begin
            due = means_due.pop_front();
            if (due.mean_value !== i_mean_value) begin
                $error("mean_value: expected %0d, actual %0d", due.mean_value, i_mean_value);
                mismatches++;
            end
            if (due.centre_row !== i_centre_row) begin
                $error("centre_row: expected %0d, actual %0d", due.centre_row, i_centre_row);
                mismatches++;
            end
            if (due.centre_col !== i_centre_col) begin
                $error("centre_col: expected %0d, actual %0d", due.centre_col, i_centre_col);
                mismatches++;
            end
            if (due.frame_last !== i_frame_last) begin
                $error("frame_last: expected %0d, actual %0d", due.frame_last, i_frame_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            row_at     = '0;
            col_at     = '0;
            mismatches = 0;
            means_due.delete();
            for (int k = 0; k < 6; k++) window_px[k] = '0;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_FRAME_WIDTH: begin
                        width_reg = i_pwdata[FW_W-1:0];
                        row_at    = '0;
                        col_at    = '0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_pwdata[FH_W-1:0];
                        row_at     = '0;
                        col_at     = '0;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) compare_mean();
            if (i_in_valid && i_in_ready) slide_window(i_pixel);
        end
        o_fail_count <= mismatches;
        o_pending    <= means_due.size();
    end

endmodule

// ===== tb/mean_filter_3x3_test.sv =====
`timescale 1ns / 1ps
// Top of the 3x3 mean filter testbench: clock, reset, size register writes,
// pixel stimulus with random idling, watchdog and verdict.
// Depends on mf3_pkg, mean_filter_3x3 and mean_filter_3x3_checker.
module mean_filter_3x3_test;
    import mf3_pkg::*;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 500;

    typedef enum int {
        PIX_WHITE,
        PIX_BLACK,
        PIX_EXTREMES,
        PIX_RANDOM
    } t_pix_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_valid;
    logic             o_ready;
    logic [PIX_W-1:0] i_pixel;
    logic             o_valid;
    logic             i_ready;
    logic [PIX_W-1:0] o_mean_value;
    logic [ROW_W-1:0] o_centre_row;
    logic [COL_W-1:0] o_centre_col;
    logic             o_frame_last;

    int fail_count;
    int pending;
    int quiet_cycles;
    bit idle_on;

    mean_filter_3x3 #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) uut (.*);

    mean_filter_3x3_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_pixel     (i_pixel),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_mean_value(o_mean_value),
        .i_centre_row(o_centre_row),
        .i_centre_col(o_centre_col),
        .i_frame_last(o_frame_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always begin
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        i_valid <= 1'b1;
        i_pixel <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // hold the input until every pending mean is out, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixels(input int n, input t_pix_mode mode, input int pause_at);
        logic [PIX_W-1:0] pix;
        for (int i = 1; i <= n; i++) begin
            case (mode)
                PIX_WHITE:    pix = 8'hFF;
                PIX_BLACK:    pix = 8'h00;
                PIX_EXTREMES: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:      pix = PIX_W'($urandom_range(0, 255));
            endcase
            push_pixel(pix);
            if (i == pause_at) drain();
        end
    endtask

    task automatic run_frames(input int quota, input int calm_after);
        int        sent;
        int        w;
        int        h;
        int        n;
        int        pause_at;
        t_pix_mode mode;
        sent = 0;
        while (sent < quota) begin
            idle_on = (sent < calm_after) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(0, 2);
            end else if ($urandom_range(0, 5) == 0) begin
                w = $urandom_range(13, 40);
            end else begin
                w = $urandom_range(3, 12);
            end
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            set_frame(w, h);
            n = ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h) * $urandom_range(1, 2);
            if (n > quota - sent) n = quota - sent;
            // cut the stream short now and then; the next size write restarts the frame
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : 0;
            mode = ($urandom_range(0, 3) == 0) ? t_pix_mode'($urandom_range(0, 2)) : PIX_RANDOM;
            send_pixels(n, mode, pause_at);
            drain();
            sent += n;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_ready = 1'b1;
        idle_on = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes below the minimum saturate to a 3x3 frame
        set_frame(0, 0);
        send_pixels(9, PIX_WHITE, 9);
        send_pixels(9, PIX_BLACK, 0);
        send_pixels(9, PIX_EXTREMES, 0);
        drain();

        run_frames(280, 280);

        idle_on = 1'b1;
        set_frame((1 << FW_W) - 1, 3);
        send_pixels(64, PIX_RANDOM, 0);
        drain();
        set_frame(3, (1 << FH_W) - 1);
        send_pixels(60, PIX_RANDOM, 0);
        drain();

        run_frames(270, 170);
        idle_on = 1'b0;
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mf3_pkg.sv
design/mf3_line_mem.sv
design/mf3_window.sv
design/mf3_out_fifo.sv
design/mean_filter_3x3.sv
tb/mean_filter_3x3_checker.sv
tb/mean_filter_3x3_test.sv
